// ----- rtl/rmarq_pkg.sv -----
// types and constants shared by the reliable message arq stream block
`default_nettype none

package rmarq_pkg;

  localparam int MSG_ID_WIDTH = 16;
  localparam int REL_ID_WIDTH = 32;
  localparam int TAG_WIDTH    = 16;
  localparam int RETRY_WIDTH  = 8;
  localparam int CLOCK_WIDTH  = 32;
  localparam int FRAMES_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int S_TDATA_WIDTH  = 120;
  localparam int M_TDATA_WIDTH  = 128;

  localparam logic [MSG_ID_WIDTH-1:0] MSGID_DGRAM = '1;
  localparam logic [REL_ID_WIDTH-1:0] REL_ID_MAX  = '1;

  localparam logic [FRAMES_WIDTH-1:0] RETRANSMIT_RESET = 16'd200;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RETRANSMIT = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RELIABLE   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CONNECTED  = 2'd2;

  typedef enum logic [2:0] {
    ACT_RECEIVE = 3'd0,
    ACT_HEADER  = 3'd1,
    ACT_ENQUEUE = 3'd2,
    ACT_POLL    = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_FLUSH   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_FIRST   = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_NACK    = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic enq;
    logic poll;
    logic tick;
    logic flush;
  } bl_ctl_t;

  typedef struct packed {
    logic hold;
    logic carrier_pending;
    logic all_acked;
  } ack_stat_t;

  typedef struct packed {
    logic                   enq_ok;
    kind_t                  kind;
    logic [RETRY_WIDTH-1:0] retries;
  } bl_res_t;

endpackage

`default_nettype wire

// ----- rtl/reliable_message_arq_stream.sv -----
// top level: stop-and-wait arq endpoint with id stamping and ack tracking
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser action, s_tdata receive/header/enqueue fields
//  m_*       out  m_tvalid/m_tready  m_tuser send kind, m_tdata result fields
//  cfg_*     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one beat per cycle sustained while m_tready stays high; an accepted beat passes the
// input register, then the result register, and leaves on m_* from the result register
// reset puts the control, id, backlog and configuration state at its reset value, no clearing pass
// m_tready low holds the result; s_tready drops once the input register also waits
`default_nettype none

module reliable_message_arq_stream #(
  parameter int BACKLOG_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // msg_id, rel_id, ack_msg_id, ack_rel_id, want_reliable, entry_tag
  input  wire logic [rmarq_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
  // action
  input  wire logic [2:0]                           s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // ok, send_tag, retries, hdr_msg_id, hdr_rel_id, hdr_ack_msg_id, hdr_ack_rel_id
  output logic [rmarq_pkg::M_TDATA_WIDTH-1:0]       m_tdata,
  // send_kind
  output logic [1:0]                                m_tuser,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rmarq_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [rmarq_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import rmarq_pkg::*;

  // configuration
  logic [FRAMES_WIDTH-1:0] retransmit_frames;
  logic                    reliable_enable;
  logic                    connected;

  // input register
  logic                    in_valid;
  action_t                 in_action;
  logic [MSG_ID_WIDTH-1:0] in_msg_id, in_ack_msg_id;
  logic [REL_ID_WIDTH-1:0] in_rel_id, in_ack_rel_id;
  logic                    in_want;
  logic [TAG_WIDTH-1:0]    in_tag;

  // id state
  logic [MSG_ID_WIDTH-1:0] next_out_id, next_out_id_next;
  logic [REL_ID_WIDTH-1:0] next_out_rel_id, next_out_rel_id_next;
  logic [MSG_ID_WIDTH-1:0] got_msg_id, got_msg_id_next;
  logic [REL_ID_WIDTH-1:0] got_rel_id, got_rel_id_next;
  logic [MSG_ID_WIDTH-1:0] peer_acked_id, peer_acked_id_next;
  logic [REL_ID_WIDTH-1:0] peer_acked_rel_id, peer_acked_rel_id_next;
  logic [MSG_ID_WIDTH-1:0] rel_carrier_id, rel_carrier_id_next;

  // result register
  logic                    out_valid;
  logic                    out_ok;
  kind_t                   out_kind;
  logic [RETRY_WIDTH-1:0]  out_retries;
  logic [MSG_ID_WIDTH-1:0] out_hdr_msg_id, out_hdr_ack_msg_id;
  logic [REL_ID_WIDTH-1:0] out_hdr_rel_id, out_hdr_ack_rel_id;

  logic                    res_ok;
  logic [MSG_ID_WIDTH-1:0] res_hdr_msg_id, res_hdr_ack_msg_id;
  logic [REL_ID_WIDTH-1:0] res_hdr_rel_id, res_hdr_ack_rel_id;

  logic                    fire;
  logic [MSG_ID_WIDTH-1:0] pa;
  logic [REL_ID_WIDTH-1:0] par;
  bl_ctl_t                 bl_ctl;
  ack_stat_t               ack;
  bl_res_t                 bl_res;
  logic [TAG_WIDTH-1:0]    send_tag;

  assign fire      = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retransmit_frames <= RETRANSMIT_RESET;
      reliable_enable   <= 1'b1;
      connected         <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RETRANSMIT: retransmit_frames <= cfg_data;
        CFG_RELIABLE:   reliable_enable   <= cfg_data[0];
        CFG_CONNECTED:  connected         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action     <= action_t'(s_tuser);
      in_msg_id     <= s_tdata[15:0];
      in_rel_id     <= s_tdata[47:16];
      in_ack_msg_id <= s_tdata[63:48];
      in_ack_rel_id <= s_tdata[95:64];
      in_want       <= s_tdata[96];
      in_tag        <= s_tdata[112:97];
    end
  end

  assign ack.hold            = (peer_acked_id >= next_out_id) ||
                               (peer_acked_rel_id >= next_out_rel_id);
  assign ack.carrier_pending = peer_acked_id < rel_carrier_id;
  assign ack.all_acked       = peer_acked_rel_id == (next_out_rel_id - 1'b1);

  assign pa  = (in_ack_msg_id > peer_acked_id) ? in_ack_msg_id : peer_acked_id;

  always_comb begin
    par = (in_ack_rel_id > peer_acked_rel_id) ? in_ack_rel_id : peer_acked_rel_id;
    if (par > next_out_rel_id) begin
      par = next_out_rel_id;
    end
  end

  always_comb begin
    next_out_id_next       = next_out_id;
    next_out_rel_id_next   = next_out_rel_id;
    got_msg_id_next        = got_msg_id;
    got_rel_id_next        = got_rel_id;
    peer_acked_id_next     = peer_acked_id;
    peer_acked_rel_id_next = peer_acked_rel_id;
    rel_carrier_id_next    = rel_carrier_id;
    res_ok                 = 1'b0;
    res_hdr_msg_id         = '0;
    res_hdr_rel_id         = '0;
    res_hdr_ack_msg_id     = '0;
    res_hdr_ack_rel_id     = '0;
    bl_ctl                 = '0;
    bl_ctl.load            = fire;

    unique case (in_action)
      ACT_RECEIVE: begin
        if (in_msg_id == MSGID_DGRAM) begin
          res_ok = 1'b1;
        end else if (connected && (got_msg_id < in_msg_id)) begin
          got_msg_id_next    = in_msg_id;
          peer_acked_id_next = pa;
          if (pa < next_out_id) begin
            if (reliable_enable) begin
              if ((in_rel_id != '0) && (in_rel_id > got_rel_id)) begin
                got_rel_id_next = in_rel_id;
              end
              peer_acked_rel_id_next = par;
              res_ok = 1'b1;
            end else begin
              res_ok = in_rel_id == '0;
            end
          end
        end
      end
      ACT_HEADER: begin
        res_ok             = 1'b1;
        res_hdr_msg_id     = next_out_id;
        res_hdr_ack_msg_id = got_msg_id;
        if (in_want) begin
          if (!reliable_enable) begin
            res_ok = 1'b0;
          end else begin
            res_hdr_rel_id       = next_out_rel_id;
            rel_carrier_id_next  = next_out_id;
            next_out_rel_id_next = (next_out_rel_id == REL_ID_MAX) ?
                                   REL_ID_WIDTH'(1) : next_out_rel_id + 1'b1;
          end
        end
        if (reliable_enable) begin
          res_hdr_ack_rel_id = got_rel_id;
        end
        next_out_id_next = (next_out_id >= (MSGID_DGRAM - 1'b1)) ?
                           MSG_ID_WIDTH'(1) : next_out_id + 1'b1;
      end
      ACT_ENQUEUE: begin
        bl_ctl.enq = fire;
        res_ok     = bl_res.enq_ok;
      end
      ACT_POLL: begin
        bl_ctl.poll = fire;
        res_ok      = bl_res.kind != KIND_NONE;
      end
      ACT_TICK: begin
        bl_ctl.tick = fire;
      end
      ACT_FLUSH: begin
        bl_ctl.flush        = fire;
        rel_carrier_id_next = '0;
      end
      default: ;
    endcase
  end

  rmarq_backlog #(
    .BACKLOG_DEPTH(BACKLOG_DEPTH)
  ) u_backlog (
    .clk              (clk),
    .rst              (rst),
    .ctl              (bl_ctl),
    .entry_tag        (in_tag),
    .reliable_enable  (reliable_enable),
    .retransmit_frames(retransmit_frames),
    .ack              (ack),
    .res              (bl_res),
    .send_tag         (send_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      next_out_id       <= MSG_ID_WIDTH'(1);
      next_out_rel_id   <= REL_ID_WIDTH'(1);
      got_msg_id        <= '0;
      got_rel_id        <= '0;
      peer_acked_id     <= '0;
      peer_acked_rel_id <= '0;
      rel_carrier_id    <= '0;
    end else if (fire) begin
      next_out_id       <= next_out_id_next;
      next_out_rel_id   <= next_out_rel_id_next;
      got_msg_id        <= got_msg_id_next;
      got_rel_id        <= got_rel_id_next;
      peer_acked_id     <= peer_acked_id_next;
      peer_acked_rel_id <= peer_acked_rel_id_next;
      rel_carrier_id    <= rel_carrier_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ok             <= res_ok;
      out_kind           <= (in_action == ACT_POLL) ? bl_res.kind : KIND_NONE;
      out_retries        <= (in_action == ACT_POLL) ? bl_res.retries : '0;
      out_hdr_msg_id     <= res_hdr_msg_id;
      out_hdr_rel_id     <= res_hdr_rel_id;
      out_hdr_ack_msg_id <= res_hdr_ack_msg_id;
      out_hdr_ack_rel_id <= res_hdr_ack_rel_id;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {7'b0, out_hdr_ack_rel_id, out_hdr_ack_msg_id, out_hdr_rel_id,
                     out_hdr_msg_id, out_retries,
                     (out_kind != KIND_NONE) ? send_tag : {TAG_WIDTH{1'b0}}, out_ok};

endmodule

`default_nettype wire

// ----- rtl/rmarq_backlog.sv -----
// retransmit backlog: circular tag store, head entry state and frame clock
`default_nettype none

module rmarq_backlog #(
  parameter int BACKLOG_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rmarq_pkg::bl_ctl_t             ctl,
  input  wire logic [rmarq_pkg::TAG_WIDTH-1:0] entry_tag,
  input  wire logic                           reliable_enable,
  input  wire logic [rmarq_pkg::FRAMES_WIDTH-1:0] retransmit_frames,
  input  wire rmarq_pkg::ack_stat_t           ack,
  output rmarq_pkg::bl_res_t                  res,
  output logic [rmarq_pkg::TAG_WIDTH-1:0]     send_tag
);
  import rmarq_pkg::*;

  localparam int PTR_W = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(BACKLOG_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BACKLOG_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BACKLOG_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  logic [TAG_WIDTH-1:0]   tag_mem [BACKLOG_DEPTH];

  logic [PTR_W-1:0]       write_slot, write_slot_next;
  logic [PTR_W-1:0]       read_slot, read_slot_next;
  logic [CNT_W-1:0]       count, count_next;
  logic                   head_sent, head_sent_next;
  logic [RETRY_WIDTH-1:0] head_retries, head_retries_next;
  logic [CLOCK_WIDTH-1:0] head_deadline, head_deadline_next;
  logic [CLOCK_WIDTH-1:0] frame_clock, frame_clock_next;

  logic [PTR_W-1:0]       wr_after, rd_after, rd_addr;
  logic                   mem_we;
  logic [CLOCK_WIDTH-1:0] armed, late;
  logic [RETRY_WIDTH-1:0] bumped;
  logic                   expired;

  assign wr_after = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign rd_after = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;
  assign armed    = frame_clock + CLOCK_WIDTH'(retransmit_frames);
  assign late     = frame_clock - head_deadline;
  assign expired  = (late != '0) && !late[CLOCK_WIDTH-1];
  assign bumped   = (head_retries == '1) ? head_retries : head_retries + 1'b1;

  always_comb begin
    write_slot_next    = write_slot;
    read_slot_next     = read_slot;
    count_next         = count;
    head_sent_next     = head_sent;
    head_retries_next  = head_retries;
    head_deadline_next = head_deadline;
    frame_clock_next   = frame_clock;
    rd_addr            = read_slot;
    mem_we             = 1'b0;
    res                = '0;

    if (ctl.enq && reliable_enable && (count != FULL_CNT)) begin
      mem_we          = 1'b1;
      write_slot_next = wr_after;
      count_next      = count + 1'b1;
      res.enq_ok      = 1'b1;
    end

    if (ctl.poll && !ack.hold && (count != '0)) begin
      if (!head_sent) begin
        head_sent_next     = 1'b1;
        head_deadline_next = armed;
        res.kind           = KIND_FIRST;
        res.retries        = head_retries;
      end else if (ack.carrier_pending) begin
        if (expired) begin
          head_retries_next  = bumped;
          head_deadline_next = armed;
          res.kind           = KIND_TIMEOUT;
          res.retries        = bumped;
        end
      end else if (ack.all_acked) begin
        // retire head, start next entry if one waits
        count_next        = count - 1'b1;
        read_slot_next    = rd_after;
        rd_addr           = rd_after;
        head_retries_next = '0;
        if (count > ONE_CNT) begin
          head_sent_next     = 1'b1;
          head_deadline_next = armed;
          res.kind           = KIND_FIRST;
        end else begin
          head_sent_next = 1'b0;
        end
      end else begin
        head_retries_next  = bumped;
        head_deadline_next = armed;
        res.kind           = KIND_NACK;
        res.retries        = bumped;
      end
    end

    if (ctl.tick) begin
      frame_clock_next = frame_clock + 1'b1;
    end

    if (ctl.flush) begin
      write_slot_next   = LAST_SLOT;
      read_slot_next    = '0;
      count_next        = '0;
      head_sent_next    = 1'b0;
      head_retries_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= LAST_SLOT;
      read_slot    <= '0;
      count        <= '0;
      head_sent    <= 1'b0;
      head_retries <= '0;
      frame_clock  <= '0;
    end else if (ctl.load) begin
      write_slot   <= write_slot_next;
      read_slot    <= read_slot_next;
      count        <= count_next;
      head_sent    <= head_sent_next;
      head_retries <= head_retries_next;
      frame_clock  <= frame_clock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      head_deadline <= head_deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && mem_we) begin
      tag_mem[wr_after] <= entry_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      send_tag <= tag_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rmarq_checker.sv -----
// port checker for the reliable message arq stream block, bound to the top level
`default_nettype none

module rmarq_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [rmarq_pkg::M_TDATA_WIDTH-1:0] m_tdata,
  input wire logic [1:0]                          m_tuser
);
  import rmarq_pkg::*;

  // output beat held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no beat right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // nothing to send carries no tag and no retry count
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_NONE) |-> (m_tdata[24:1] == '0))
    else $error("tag or retries without send");

  // a send always reports ok
  a_send_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_NONE) |-> m_tdata[0])
    else $error("send without ok");

  // first send never carries retries
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_FIRST) |-> (m_tdata[24:17] == '0))
    else $error("first send with retries");

endmodule

bind reliable_message_arq_stream rmarq_checker u_rmarq_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
